[src/dgs_pkg.sv]
// ----------------------------------------------------------------------------
// dgs_pkg: shared types and codes of the directed graph store
// Command, status and update codes, and the probe flags that run down the
// chain of node cells.
// ----------------------------------------------------------------------------
package dgs_pkg;

	localparam logic [2:0] CMD_ADD_NODE = 3'd0;
	localparam logic [2:0] CMD_DEL_NODE = 3'd1;
	localparam logic [2:0] CMD_ADD_EDGE = 3'd2;
	localparam logic [2:0] CMD_DEL_EDGE = 3'd3;
	localparam logic [2:0] CMD_FIND     = 3'd4;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_DUP       = 2'd3;

	// update applied to all cells in the same cycle
	localparam logic [2:0] AP_NONE     = 3'd0;
	localparam logic [2:0] AP_ADD_NODE = 3'd1;
	localparam logic [2:0] AP_DEL_NODE = 3'd2;
	localparam logic [2:0] AP_ADD_EDGE = 3'd3;
	localparam logic [2:0] AP_DEL_EDGE = 3'd4;

	typedef struct packed {
		logic found_s;
		logic found_t;
		logic found_free;
	} probe_t;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] key;
	} apply_t;

endpackage

[src/dgs_cell.sv]
// ----------------------------------------------------------------------------
// dgs_cell: one node slot of the graph store
// Holds key, valid bit and adjacency row; merges its match into the probe
// from its left neighbor and registers it for the right neighbor.
// ----------------------------------------------------------------------------
module dgs_cell #(
	parameter int NODES = 16,
	localparam int IW = $clog2(NODES)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [IW-1:0]   index,
	input  logic [7:0]      node_key,
	input  logic [7:0]      target_key,
	input  dgs_pkg::probe_t probe_in,
	input  logic [IW-1:0]   s_in,
	input  logic [IW-1:0]   t_in,
	input  logic [IW-1:0]   f_in,
	output dgs_pkg::probe_t probe_out,
	output logic [IW-1:0]   s_out,
	output logic [IW-1:0]   t_out,
	output logic [IW-1:0]   f_out,
	input  dgs_pkg::apply_t apply,
	input  logic [IW-1:0]   apply_s,
	input  logic [IW-1:0]   apply_dst
);
	import dgs_pkg::*;

	logic [7:0]       key_q;
	logic             valid_q;
	logic [NODES-1:0] row_q;

	logic             valid_d;
	logic [NODES-1:0] row_d;
	logic             key_we;
	logic             hit;
	logic             match_s;
	logic             match_t;

	assign match_s = valid_q && (key_q == node_key);
	assign match_t = valid_q && (key_q == target_key);
	assign hit     = (index == apply_s);

	always_comb begin
		valid_d = valid_q;
		row_d   = row_q;
		key_we  = 1'b0;
		unique case (apply.op)
			AP_NONE: begin
			end
			AP_ADD_NODE: begin
				if (hit) begin
					valid_d = 1'b1;
					row_d   = '0;
					key_we  = 1'b1;
				end
			end
			AP_DEL_NODE: begin
				// drop the edge into the freed slot, and the slot's own row
				row_d[apply_s] = 1'b0;
				if (hit) begin
					row_d   = '0;
					valid_d = 1'b0;
				end
			end
			AP_ADD_EDGE: begin
				if (hit) begin
					row_d[apply_dst] = 1'b1;
				end
			end
			AP_DEL_EDGE: begin
				if (hit) begin
					row_d[apply_dst] = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			row_q     <= '0;
			probe_out <= '0;
		end else begin
			valid_q              <= valid_d;
			row_q                <= row_d;
			probe_out.found_s    <= probe_in.found_s | match_s;
			probe_out.found_t    <= probe_in.found_t | match_t;
			probe_out.found_free <= probe_in.found_free | !valid_q;
		end
	end

	// first hit from the left wins
	always_ff @(posedge clk) begin
		s_out <= probe_in.found_s ? s_in : index;
		t_out <= probe_in.found_t ? t_in : index;
		f_out <= probe_in.found_free ? f_in : index;
		if (key_we) begin
			key_q <= apply.key;
		end
	end

endmodule

[src/directed_graph_store_unit.sv]
// ----------------------------------------------------------------------------
// directed_graph_store_unit: directed graph adjacency store
// Keeps up to MAX_NODES nodes, named by 8-bit keys, with one adjacency row
// per slot. A command word is taken when start is high and busy is low; the
// unit then stays busy through the scan and decide states and presents one
// result word (status, slot) when busy falls, with done high for one cycle.
// The receiver cannot stall: sample status and slot whenever done is high.
// A new command word may be issued in the same cycle that done is high.
// The scan is the probe that walks the chain of node cells, one cell per
// cycle, to find the source, the target and the lowest free slot; the
// update then reaches every cell at once. Add node takes the lowest free
// slot, refuses a key already present (status 3) before it refuses a full
// table (status 2); delete node also clears every edge that points to the
// node. The slot field is zero whenever status is nonzero.
// ----------------------------------------------------------------------------
module directed_graph_store_unit #(
	parameter int MAX_NODES = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] cmd,
	input  logic [7:0] node_key,
	input  logic [7:0] target_key,
	output logic       done,
	output logic [1:0] status,
	output logic [3:0] slot
);
	import dgs_pkg::*;

	localparam int IW = $clog2(MAX_NODES);
	localparam int EW = (IW > 4) ? IW : 4;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_DECIDE = 2'd2;

	logic [1:0]    state_q;
	logic [IW-1:0] cnt_q;
	logic [2:0]    cmd_q;
	logic [7:0]    key_q;
	logic [7:0]    tkey_q;
	logic          done_q;
	logic [1:0]    status_q;
	logic [3:0]    slot_q;

	// probe chain: entry 0 is the empty probe, entry MAX_NODES the final one
	probe_t        chain_flags [0:MAX_NODES];
	logic [IW-1:0] chain_s     [0:MAX_NODES];
	logic [IW-1:0] chain_t     [0:MAX_NODES];
	logic [IW-1:0] chain_f     [0:MAX_NODES];

	apply_t        apply;
	logic [IW-1:0] apply_s;
	logic [IW-1:0] apply_dst;
	logic [1:0]    status_d;
	logic [IW-1:0] slot_idx_d;
	logic [EW-1:0] slot_ext;
	probe_t        fin;

	assign chain_flags[0] = '0;
	assign chain_s[0]     = '0;
	assign chain_t[0]     = '0;
	assign chain_f[0]     = '0;

	genvar g;
	generate
		for (g = 0; g < MAX_NODES; g++) begin : g_cell
			dgs_cell #(.NODES(MAX_NODES)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.index      (IW'(g)),
				.node_key   (key_q),
				.target_key (tkey_q),
				.probe_in   (chain_flags[g]),
				.s_in       (chain_s[g]),
				.t_in       (chain_t[g]),
				.f_in       (chain_f[g]),
				.probe_out  (chain_flags[g+1]),
				.s_out      (chain_s[g+1]),
				.t_out      (chain_t[g+1]),
				.f_out      (chain_f[g+1]),
				.apply      (apply),
				.apply_s    (apply_s),
				.apply_dst  (apply_dst)
			);
		end
	endgenerate

	assign fin = chain_flags[MAX_NODES];

	// Decide the outcome from the final probe; the update goes out only in
	// the decide cycle, so every cell sees it at the same edge.
	always_comb begin
		status_d   = ST_DONE;
		slot_idx_d = '0;
		apply.op   = AP_NONE;
		apply.key  = key_q;
		apply_s    = chain_s[MAX_NODES];
		apply_dst  = chain_t[MAX_NODES];
		unique case (cmd_q)
			CMD_ADD_NODE: begin
				if (fin.found_s) begin
					status_d = ST_DUP;
				end else if (!fin.found_free) begin
					status_d = ST_FULL;
				end else begin
					apply.op   = AP_ADD_NODE;
					apply_s    = chain_f[MAX_NODES];
					slot_idx_d = chain_f[MAX_NODES];
				end
			end
			CMD_DEL_NODE: begin
				if (!fin.found_s) begin
					status_d = ST_NOT_FOUND;
				end else begin
					apply.op   = AP_DEL_NODE;
					slot_idx_d = chain_s[MAX_NODES];
				end
			end
			CMD_ADD_EDGE, CMD_DEL_EDGE: begin
				if (!(fin.found_s && fin.found_t)) begin
					status_d = ST_NOT_FOUND;
				end else begin
					apply.op   = (cmd_q == CMD_ADD_EDGE) ? AP_ADD_EDGE : AP_DEL_EDGE;
					slot_idx_d = chain_s[MAX_NODES];
				end
			end
			CMD_FIND: begin
				if (!fin.found_s) begin
					status_d = ST_NOT_FOUND;
				end else begin
					slot_idx_d = chain_s[MAX_NODES];
				end
			end
			default: begin
			end
		endcase
		// hold off the update outside the decide cycle
		if (state_q != S_DECIDE) begin
			apply.op = AP_NONE;
		end
	end

	assign slot_ext = EW'(slot_idx_d);

	// Sequencer: latch the command word, let the probe walk the chain of cells
	// in the scan state, then decide and present the result word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_DECIDE);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_SCAN;
						cnt_q   <= '0;
					end
				end
				S_SCAN: begin
					if (cnt_q == IW'(MAX_NODES - 1)) begin
						state_q <= S_DECIDE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DECIDE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// command and result payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			cmd_q  <= cmd;
			key_q  <= node_key;
			tkey_q <= target_key;
		end
		if (state_q == S_DECIDE) begin
			status_q <= status_d;
			slot_q   <= slot_ext[3:0];
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign status = status_q;
	assign slot   = slot_q;

`ifndef SYNTH
	a_done_after_decide: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_DECIDE))
		else $error("result word without a decide cycle");

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && state_q == S_SCAN))
		else $error("accepted command did not start a scan");

	a_scan_leads_on: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |=> (state_q == S_SCAN || state_q == S_DECIDE))
		else $error("scan left without deciding");

	a_slot_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_DONE) |-> (slot == 4'd0))
		else $error("nonzero slot with an error status");
`endif

endmodule
